// File: rtl/spectral_frame_compander_unit_macros.svh
// ---------------------------------------------------------------------------
// spectral frame compander assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef SPECTRAL_FRAME_COMPANDER_UNIT_MACROS_SVH
`define SPECTRAL_FRAME_COMPANDER_UNIT_MACROS_SVH

// same-cycle implication
`define SFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sfc_pkg.sv
// ---------------------------------------------------------------------------
// sfc_pkg
// types and constants of the spectral frame compander
// ---------------------------------------------------------------------------
package sfc_pkg;

  localparam int AMP_W  = 24;
  localparam int Q16_W  = 17;
  localparam int GAIN_W = 20;
  localparam int VAL_W  = 20;
  localparam int CNT_W  = 7;
  localparam int IDX_W  = 2;

  localparam logic [VAL_W-1:0] Q4_16_MAX = 20'hFFFFF;

  localparam logic [Q16_W-1:0]  CT_RESET = 17'd52429;
  localparam logic [GAIN_W-1:0] CG_RESET = 20'd32768;
  localparam logic [Q16_W-1:0]  ET_RESET = 17'd6554;
  localparam logic [GAIN_W-1:0] EG_RESET = 20'd131072;

  typedef enum logic [IDX_W-1:0] {
    REG_CT = 2'd0,
    REG_CG = 2'd1,
    REG_ET = 2'd2,
    REG_EG = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [AMP_W-1:0] bin_amplitude;
    logic             frame_end;
  } in_item_t;

  typedef struct packed {
    logic [Q16_W-1:0] out_amplitude;
    logic             out_last;
    logic             peak_zero_error;
  } out_item_t;

  typedef struct packed {
    logic [Q16_W-1:0]  compress_threshold;
    logic [GAIN_W-1:0] compress_gain;
    logic [Q16_W-1:0]  expand_threshold;
    logic [GAIN_W-1:0] expand_gain;
  } cfg_t;

  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
    logic [AMP_W-1:0] peak;
  } frame_desc_t;

endpackage

// File: rtl/sfc_ram.sv
// ---------------------------------------------------------------------------
// sfc_ram
// simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module sfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/sfc_div.sv
// ---------------------------------------------------------------------------
// sfc_div
// restoring divider, x * 2^16 / d with x <= d, one quotient bit per cycle
// ---------------------------------------------------------------------------
module sfc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sfc_pkg::AMP_W-1:0]  dividend,
  input  logic [sfc_pkg::AMP_W-1:0]  divisor,
  output logic                       done,
  output logic [sfc_pkg::Q16_W-1:0]  quot
);
  import sfc_pkg::*;

  logic [AMP_W:0]   r_r, r_nxt;
  logic [AMP_W-1:0] d_r, d_nxt;
  logic [Q16_W-1:0] q_r, q_nxt;
  logic [4:0]       step_r, step_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic             ge;
  logic [AMP_W:0]   rem;

  always_comb begin
    ge       = r_r >= {1'b0, d_r};
    rem      = ge ? (r_r - {1'b0, d_r}) : r_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      r_nxt    = {1'b0, dividend};
      d_nxt    = divisor;
      q_nxt    = '0;
      step_nxt = 5'd16;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      q_nxt = {q_r[Q16_W-2:0], ge};
      // remainder stays below the divisor, so the shift cannot overflow
      r_nxt = {rem[AMP_W-1:0], 1'b0};
      if (step_r == 5'd0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    r_r    <= r_nxt;
    d_r    <= d_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// File: rtl/sfc_front.sv
// ---------------------------------------------------------------------------
// sfc_front
// loads bins into a store bank, tracks the peak, queues finished frames
// ---------------------------------------------------------------------------
module sfc_front #(
  parameter int FRAME_BINS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  sfc_pkg::in_item_t              in_data,
  output logic                           wr_en,
  output logic [$clog2(FRAME_BINS):0]    wr_addr,
  output logic [sfc_pkg::AMP_W-1:0]      wr_data,
  output logic                           desc_valid,
  output sfc_pkg::frame_desc_t           desc,
  input  logic                           desc_pop,
  input  logic                           frame_done
);
  import sfc_pkg::*;

  localparam int AW = $clog2(FRAME_BINS);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [AMP_W-1:0] peak_r, peak_nxt;
  logic             wbank_r, wbank_nxt;
  frame_desc_t      q_r [2];
  logic             wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]       qn_r, qn_nxt, held_r, held_nxt;
  logic             accept, push;
  logic [CNT_W-1:0] count_inc;
  logic [AMP_W-1:0] peak_upd;

  assign busy      = (held_r == 2'd2);
  assign accept    = start && !busy;
  assign count_inc = count_r + CNT_W'(1);
  assign peak_upd  = (in_data.bin_amplitude > peak_r) ? in_data.bin_amplitude : peak_r;
  // a full store closes the frame as well
  assign push      = accept && (in_data.frame_end || count_inc == CNT_W'(FRAME_BINS));

  assign wr_en   = accept;
  assign wr_addr = {wbank_r, count_r[AW-1:0]};
  assign wr_data = in_data.bin_amplitude;

  assign desc_valid = (qn_r != 2'd0);
  assign desc       = q_r[rp_r];

  always_comb begin
    count_nxt = count_r;
    peak_nxt  = peak_r;
    wbank_nxt = wbank_r;
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    if (accept) begin
      count_nxt = count_inc;
      peak_nxt  = peak_upd;
    end
    if (push) begin
      count_nxt = '0;
      peak_nxt  = '0;
      wbank_nxt = !wbank_r;
      wp_nxt    = !wp_r;
    end
    if (desc_pop) begin
      rp_nxt = !rp_r;
    end
    qn_nxt   = qn_r + {1'b0, push} - {1'b0, desc_pop};
    held_nxt = held_r + {1'b0, push} - {1'b0, frame_done};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      peak_r  <= '0;
      wbank_r <= 1'b0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      qn_r    <= '0;
      held_r  <= '0;
    end else begin
      count_r <= count_nxt;
      peak_r  <= peak_nxt;
      wbank_r <= wbank_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      qn_r    <= qn_nxt;
      held_r  <= held_nxt;
    end
    if (push) begin
      q_r[wp_r] <= '{bank: wbank_r, count: count_inc, peak: peak_upd};
    end
  end

endmodule

// File: rtl/sfc_back.sv
// ---------------------------------------------------------------------------
// sfc_back
// normalizes, companders and renormalizes one queued frame, then emits it
// ---------------------------------------------------------------------------
module sfc_back #(
  parameter int FRAME_BINS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sfc_pkg::cfg_t               cfg,
  input  logic                        desc_valid,
  input  sfc_pkg::frame_desc_t        desc,
  output logic                        desc_pop,
  output logic                        frame_done,
  output logic [$clog2(FRAME_BINS):0] rd_addr,
  input  logic [sfc_pkg::AMP_W-1:0]   rd_data,
  output logic                        out_valid,
  output sfc_pkg::out_item_t          out_data
);
  import sfc_pkg::*;

  localparam int AW = $clog2(FRAME_BINS);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_P1_RD = 10'b0000000010,
    S_P1_GO = 10'b0000000100,
    S_P1_DV = 10'b0000001000,
    S_P1_ML = 10'b0000010000,
    S_P1_AD = 10'b0000100000,
    S_P2_RD = 10'b0001000000,
    S_P2_GO = 10'b0010000000,
    S_P2_DV = 10'b0100000000,
    S_ZERO  = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    M_PASS = 2'd0,
    M_COMP = 2'd1,
    M_EXP  = 2'd2
  } mode_t;

  state_t           state_r, state_nxt;
  logic             bank_r, bank_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, i_r, i_nxt;
  logic [AMP_W-1:0] peak1_r, peak1_nxt;
  logic [VAL_W-1:0] peak2_r, peak2_nxt;
  logic [Q16_W-1:0] n_r, n_nxt;
  logic [36:0]      prod_r, prod_nxt;
  mode_t            mode_r, mode_nxt;
  logic             ov_r, ov_nxt;
  out_item_t        od_r, od_nxt;

  logic             div_start, div_done;
  logic [AMP_W-1:0] div_x, div_d;
  logic [Q16_W-1:0] div_q;
  logic             mid_we;
  logic [VAL_W-1:0] mid_wdata, mid_rdata;
  logic [VAL_W-1:0] v;
  logic [20:0]      sh;
  logic [21:0]      csum;
  logic [Q16_W-1:0] diff;
  logic [GAIN_W-1:0] gain;
  logic             last;

  assign rd_addr   = {bank_r, i_r[AW-1:0]};
  assign div_start = (state_r == S_P1_GO) || (state_r == S_P2_GO);
  assign div_x     = (state_r == S_P1_GO) ? rd_data : {{(AMP_W-VAL_W){1'b0}}, mid_rdata};
  assign div_d     = (state_r == S_P1_GO) ? peak1_r : {{(AMP_W-VAL_W){1'b0}}, peak2_r};
  assign last      = (i_r + CNT_W'(1)) == count_r;

  sfc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_x),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (div_q)
  );

  sfc_ram #(.WIDTH(VAL_W), .DEPTH(FRAME_BINS)) u_mid (
    .clk   (clk),
    .we    (mid_we),
    .waddr (i_r[AW-1:0]),
    .wdata (mid_wdata),
    .raddr (i_r[AW-1:0]),
    .rdata (mid_rdata)
  );

  // companding operand select
  always_comb begin
    if (n_r > cfg.compress_threshold) begin
      mode_nxt = M_COMP;
      diff     = n_r - cfg.compress_threshold;
      gain     = cfg.compress_gain;
    end else if (n_r < cfg.expand_threshold) begin
      mode_nxt = M_EXP;
      diff     = cfg.expand_threshold - n_r;
      gain     = cfg.expand_gain;
    end else begin
      mode_nxt = M_PASS;
      diff     = '0;
      gain     = '0;
    end
    prod_nxt = {{Q16_W{1'b0}}, gain} * {{GAIN_W{1'b0}}, diff};
  end

  // companding result from the registered product
  always_comb begin
    sh   = prod_r[36:16];
    csum = {5'd0, cfg.compress_threshold} + {1'b0, sh};
    case (mode_r)
      M_COMP:  v = (csum > {2'b0, Q4_16_MAX}) ? Q4_16_MAX : csum[VAL_W-1:0];
      M_EXP:   v = (sh >= {4'd0, cfg.expand_threshold}) ? '0
                   : VAL_W'(cfg.expand_threshold - sh[Q16_W-1:0]);
      default: v = {3'd0, n_r};
    endcase
  end

  assign mid_we    = (state_r == S_P1_AD);
  assign mid_wdata = v;

  always_comb begin
    state_nxt  = state_r;
    bank_nxt   = bank_r;
    count_nxt  = count_r;
    i_nxt      = i_r;
    peak1_nxt  = peak1_r;
    peak2_nxt  = peak2_r;
    n_nxt      = n_r;
    ov_nxt     = 1'b0;
    od_nxt     = od_r;
    desc_pop   = 1'b0;
    frame_done = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (desc_valid) begin
          desc_pop  = 1'b1;
          bank_nxt  = desc.bank;
          count_nxt = desc.count;
          peak1_nxt = desc.peak;
          peak2_nxt = '0;
          i_nxt     = '0;
          state_nxt = (desc.peak == '0) ? S_ZERO : S_P1_RD;
        end
      end
      S_P1_RD: state_nxt = S_P1_GO;
      S_P1_GO: state_nxt = S_P1_DV;
      S_P1_DV: begin
        if (div_done) begin
          n_nxt     = div_q;
          state_nxt = S_P1_ML;
        end
      end
      S_P1_ML: state_nxt = S_P1_AD;
      S_P1_AD: begin
        if (v > peak2_r) begin
          peak2_nxt = v;
        end
        if (last) begin
          i_nxt     = '0;
          state_nxt = (v == '0 && peak2_r == '0) ? S_ZERO : S_P2_RD;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_P1_RD;
        end
      end
      S_P2_RD: state_nxt = S_P2_GO;
      S_P2_GO: state_nxt = S_P2_DV;
      S_P2_DV: begin
        if (div_done) begin
          ov_nxt = 1'b1;
          od_nxt = '{out_amplitude: div_q, out_last: last, peak_zero_error: 1'b0};
          i_nxt  = i_r + CNT_W'(1);
          if (last) begin
            frame_done = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_P2_RD;
          end
        end
      end
      S_ZERO: begin
        ov_nxt = 1'b1;
        od_nxt = '{out_amplitude: '0, out_last: last, peak_zero_error: 1'b1};
        i_nxt  = i_r + CNT_W'(1);
        if (last) begin
          frame_done = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    bank_r  <= bank_nxt;
    count_r <= count_nxt;
    i_r     <= i_nxt;
    peak1_r <= peak1_nxt;
    peak2_r <= peak2_nxt;
    n_r     <= n_nxt;
    prod_r  <= prod_nxt;
    mode_r  <= mode_nxt;
    od_r    <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// File: rtl/spectral_frame_compander_unit.sv
// ---------------------------------------------------------------------------
// spectral_frame_compander_unit
// peak-normalizing spectral compander over frames of up to FRAME_BINS bins
// ---------------------------------------------------------------------------
// Bins enter on in_data, one per cycle, taken when start is high and busy is
// low; frame_end, or the bin that fills FRAME_BINS, closes the frame.
// Loading runs at one bin per cycle into one of two store banks, so a second
// frame can load while the first is processed; busy rises only when both
// banks hold frames not yet emitted.
// A closed frame is processed in two passes over its bins; in each pass every
// bin goes through a shared bit-serial divider (17 steps per division), and in
// the first pass also through a multiply stage.
// Results appear on out_data with out_valid high for one cycle each, in
// arrival order, out_last on the final bin. A zero peak emits the frame as
// zeros, one per cycle, with peak_zero_error set.
// The receiver cannot stall; every strobe is a completed transaction.
// cfg_valid/cfg_ready write the four companding registers (cfg_ready is
// always high); write them only while the block is idle.
// Reset returns registers to defaults and empties both banks; no clearing
// pass is needed.
// ---------------------------------------------------------------------------
module spectral_frame_compander_unit #(
  parameter int FRAME_BINS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  sfc_pkg::in_item_t          in_data,
  output logic                       out_valid,
  output sfc_pkg::out_item_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sfc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [sfc_pkg::VAL_W-1:0]  cfg_wdata
);
  import sfc_pkg::*;

  localparam int AW = $clog2(FRAME_BINS);

  cfg_t             cfg_r, cfg_nxt;
  logic             wr_en;
  logic [AW:0]      wr_addr, rd_addr;
  logic [AMP_W-1:0] wr_data, rd_data;
  logic             desc_valid, desc_pop, frame_done;
  frame_desc_t      desc;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CT:  cfg_nxt.compress_threshold = cfg_wdata[Q16_W-1:0];
        REG_CG:  cfg_nxt.compress_gain      = cfg_wdata;
        REG_ET:  cfg_nxt.expand_threshold   = cfg_wdata[Q16_W-1:0];
        REG_EG:  cfg_nxt.expand_gain        = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{compress_threshold: CT_RESET, compress_gain: CG_RESET,
                 expand_threshold: ET_RESET, expand_gain: EG_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sfc_front #(.FRAME_BINS(FRAME_BINS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_pop   (desc_pop),
    .frame_done (frame_done)
  );

  sfc_ram #(.WIDTH(AMP_W), .DEPTH(2 * (1 << AW))) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  sfc_back #(.FRAME_BINS(FRAME_BINS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_pop   (desc_pop),
    .frame_done (frame_done),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

// File: rtl/sfc_checker.sv
// ---------------------------------------------------------------------------
// sfc_checker
// port-level checks of the spectral frame compander
// ---------------------------------------------------------------------------
`include "spectral_frame_compander_unit_macros.svh"

module sfc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input sfc_pkg::out_item_t         out_data
);
  import sfc_pkg::*;

  `SFC_ASSERT_NOW(a_amp_range, clk, rst_n, out_valid, out_data.out_amplitude <= 17'd65536, "amplitude above one")
  `SFC_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && out_data.peak_zero_error, out_data.out_amplitude == '0, "error bin not zero")
  `SFC_ASSERT_NEXT(a_err_burst, clk, rst_n, out_valid && out_data.peak_zero_error && !out_data.out_last, out_valid && out_data.peak_zero_error, "error frame broken")
  `SFC_ASSERT_NEXT(a_div_gap, clk, rst_n, out_valid && !out_data.peak_zero_error, !out_valid, "normal results too close")

endmodule

bind spectral_frame_compander_unit sfc_checker u_sfc_checker (.*);
